@@ design/wsp_pkg.sv @@
// Shared constants, types and a helper function for the projection block.
`timescale 1ns / 1ps
package wsp_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // Clip values carry 63 - F bits, so the scaled dividend always has 63 bits.
    localparam int DIV_NUM_W = 63;
    localparam int NDC_W     = DIV_NUM_W + 1;

    localparam int SIZE_W    = 14;
    localparam int CFG_IDX_W = 1;
    localparam int MAT_DEPTH = 16;
    localparam int MAT_IDX_W = 4;
    localparam int SAT_W     = 128;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    typedef struct packed {
        logic                 we;
        logic [MAT_IDX_W-1:0] idx;
    } t_coef_wr;

    // Clamp a signed value to the signed range of the given bit count.
    function automatic logic signed [SAT_W-1:0] sat_s(input logic signed [SAT_W-1:0] v,
                                                      input int bits);
        logic signed [SAT_W-1:0] lim_hi;
        logic signed [SAT_W-1:0] lim_lo;
        lim_hi = $signed((SAT_W'(1) << (bits - 1)) - SAT_W'(1));
        lim_lo = ~lim_hi;
        if (v > lim_hi) begin
            return lim_hi;
        end
        if (v < lim_lo) begin
            return lim_lo;
        end
        return v;
    endfunction

endpackage

@@ design/wsp_xform.sv @@
// Matrix store and three-stage matrix-vector transform producing clip coordinates.
`timescale 1ns / 1ps
module wsp_xform #(
    parameter int FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  wsp_pkg::t_coef_wr                     i_wr,
    input  logic [COORD_WIDTH-1:0]                i_wr_val,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]         i_pos_z,
    output logic [3:0][63-FRAC_BITS-1:0]          o_clip
);
    import wsp_pkg::*;

    localparam int W         = COORD_WIDTH;
    localparam int H         = W / 2;
    localparam int PL_W      = W + H + 1;
    localparam int PH_W      = 2 * W - H;
    localparam int ACC_W     = 2 * W + 2;
    localparam int CLIP_BITS = 63 - FRAC_BITS;

    logic [W-1:0]                r_mat [MAT_DEPTH];
    logic signed [W-1:0]         w_pos [3];
    logic signed [PL_W-1:0]      n_plo [4][3];
    logic signed [PH_W-1:0]      n_phi [4][3];
    logic signed [PL_W-1:0]      r_plo [4][3];
    logic signed [PH_W-1:0]      r_phi [4][3];
    logic signed [W-1:0]         r_m3  [4];
    logic signed [ACC_W-1:0]     n_acc [4];
    logic signed [ACC_W-1:0]     r_acc [4];
    logic [3:0][CLIP_BITS-1:0]   n_clip;
    logic [3:0][CLIP_BITS-1:0]   r_clip;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_DEPTH; i++) begin
                r_mat[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_mat[i_wr.idx] <= i_wr_val;
        end
    end

    // Each coefficient times coordinate is split into a low and a high half product.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_plo[r][c] = PL_W'(w_pos[c]) *
                              PL_W'($signed({1'b0, r_mat[MAT_IDX_W'(r * 4 + c)][H-1:0]}));
                n_phi[r][c] = PH_W'(w_pos[c]) *
                              PH_W'($signed(r_mat[MAT_IDX_W'(r * 4 + c)][W-1:H]));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_acc[r] = ACC_W'(r_m3[r]) <<< FRAC_BITS;
            for (int c = 0; c < 3; c++) begin
                n_acc[r] = n_acc[r] + (ACC_W'(r_phi[r][c]) <<< H) + ACC_W'(r_plo[r][c]);
            end
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] shr;
        logic signed [SAT_W-1:0] sat;
        for (int r = 0; r < 4; r++) begin
            shr       = r_acc[r] >>> FRAC_BITS;
            sat       = sat_s(SAT_W'(shr), CLIP_BITS);
            n_clip[r] = sat[CLIP_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_plo[r][c] <= n_plo[r][c];
                    r_phi[r][c] <= n_phi[r][c];
                end
                r_m3[r]  <= $signed(r_mat[MAT_IDX_W'(r * 4 + 3)]);
                r_acc[r] <= n_acc[r];
            end
            r_clip <= n_clip;
        end
    end

    assign o_clip = r_clip;

endmodule

@@ design/wsp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, signed result.
`timescale 1ns / 1ps
module wsp_div #(
    parameter int NUM_W = wsp_pkg::DIV_NUM_W,
    parameter int DEN_W = 46
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_neg,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic signed [NUM_W:0]   o_quo
);
    logic [DEN_W-1:0]  r_rem [NUM_W+1];
    logic [NUM_W-1:0]  r_nq  [NUM_W+1];
    logic [DEN_W-1:0]  r_den [NUM_W+1];
    logic              r_neg [NUM_W+1];
    logic [DEN_W-1:0]  n_rem [NUM_W];
    logic [NUM_W-1:0]  n_nq  [NUM_W];
    logic signed [NUM_W:0] r_quo;

    // Shift the dividend out at the top, shift quotient bits in at the bottom.
    always_comb begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int k = 0; k < NUM_W; k++) begin
            trial    = {r_rem[k], r_nq[k][NUM_W-1]};
            diff     = trial - {1'b0, r_den[k]};
            ge       = trial >= {1'b0, r_den[k]};
            n_rem[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_nq[k]  = {r_nq[k][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nq[0]  <= i_num;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_nq[k+1]  <= n_nq[k];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_quo <= r_neg[NUM_W] ? -$signed({1'b0, r_nq[NUM_W]})
                                  : $signed({1'b0, r_nq[NUM_W]});
        end
    end

    assign o_quo = r_quo;

endmodule

@@ design/wsp_map.sv @@
// Two-stage viewport mapping of normalized x and y to screen coordinates.
`timescale 1ns / 1ps
module wsp_map #(
    parameter int FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [wsp_pkg::NDC_W-1:0]   i_ndc_x,
    input  logic signed [wsp_pkg::NDC_W-1:0]   i_ndc_y,
    input  logic [wsp_pkg::SIZE_W-1:0]         i_width,
    input  logic [wsp_pkg::SIZE_W-1:0]         i_height,
    output logic [COORD_WIDTH-1:0]             o_sx,
    output logic [COORD_WIDTH-1:0]             o_sy
);
    import wsp_pkg::*;

    localparam int LO_W   = NDC_W / 2;
    localparam int HI_W   = NDC_W - LO_W;
    localparam int PLO_W  = LO_W + SIZE_W;
    localparam int PHI_W  = HI_W + SIZE_W + 1;
    localparam int PW     = NDC_W + SIZE_W + 2;
    localparam int HALF_W = SIZE_W + FRAC_BITS;

    logic [PLO_W-1:0]         r_lo_x, r_lo_y;
    logic signed [PHI_W-1:0]  r_hi_x, r_hi_y;
    logic [SIZE_W-1:0]        r_wd, r_ht;
    logic [COORD_WIDTH-1:0]   r_sx, r_sy;
    logic signed [PW-1:0]     w_tx, w_ty;
    logic signed [HALF_W-1:0] w_hw, w_hh;
    logic signed [SAT_W-1:0]  w_sx, w_sy;

    // Scaled term: floor(ndc * size * 2^(F-1) / 2^F) = (ndc * size) >>> 1.
    assign w_tx = ((PW'(r_hi_x) <<< LO_W) + PW'($signed({1'b0, r_lo_x}))) >>> 1;
    assign w_ty = ((PW'(r_hi_y) <<< LO_W) + PW'($signed({1'b0, r_lo_y}))) >>> 1;
    assign w_hw = $signed({1'b0, r_wd, {(FRAC_BITS-1){1'b0}}});
    assign w_hh = $signed({1'b0, r_ht, {(FRAC_BITS-1){1'b0}}});
    assign w_sx = sat_s(SAT_W'(w_hw) + SAT_W'(w_tx), COORD_WIDTH);
    assign w_sy = sat_s(SAT_W'(w_hh) - SAT_W'(w_ty), COORD_WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_x <= PLO_W'(i_ndc_x[LO_W-1:0]) * PLO_W'(i_width);
            r_lo_y <= PLO_W'(i_ndc_y[LO_W-1:0]) * PLO_W'(i_height);
            r_hi_x <= PHI_W'($signed(i_ndc_x[NDC_W-1:LO_W])) *
                      PHI_W'($signed({1'b0, i_width}));
            r_hi_y <= PHI_W'($signed(i_ndc_y[NDC_W-1:LO_W])) *
                      PHI_W'($signed({1'b0, i_height}));
            r_wd   <= i_width;
            r_ht   <= i_height;
            r_sx   <= w_sx[COORD_WIDTH-1:0];
            r_sy   <= w_sy[COORD_WIDTH-1:0];
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

@@ design/world_to_screen_projection.sv @@
// Perspective projection of world points to viewport coordinates, top level.
// Each input transfer passes 3 transform stages, 65 divider stages, 2 mapping
// stages and 1 output register on its way to the output port.
// One item per cycle unless output stalls; the 63-stage divider chain sets depth.
// Reset clears the pipeline valid bits, the 16-entry matrix (all zeros) and the
// viewport registers (1920 x 1080) together; no clearing pass is needed.
`timescale 1ns / 1ps
module world_to_screen_projection #(
    parameter int FRAC_BITS   = wsp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = wsp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [wsp_pkg::SIZE_W-1:0]                 i_cfg_data,
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // coef_index, coef_value, pos_x, pos_y, pos_z, zero pad
    input  logic [((4+4*COORD_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    // mode
    input  logic                                       i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // screen_x, screen_y, screen_depth, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         o_m_axis_tdata,
    // visible
    output logic                                       o_m_axis_tuser
);
    import wsp_pkg::*;

    localparam int W         = COORD_WIDTH;
    localparam int CLIP_BITS = 63 - FRAC_BITS;
    localparam int DEN_W     = CLIP_BITS - 1;
    localparam int NEAR_W    = ((1 << FRAC_BITS) + 50) / 100;
    localparam int OUT_DW    = ((3 * W + 7) / 8) * 8;
    localparam int DIV_LAT   = DIV_NUM_W + 2;
    localparam int LAT       = DIV_LAT + 6;
    localparam int VIS_LAT   = LAT - 3;

    logic                         w_adv;
    logic                         w_acc;
    t_coef_wr                     w_wr;
    logic [3:0][CLIP_BITS-1:0]    w_clip;
    logic                         w_vis_now;
    logic [DIV_NUM_W-1:0]         w_num [3];
    logic                         w_neg [3];
    logic signed [NDC_W-1:0]      w_ndc [3];
    logic [W-1:0]                 w_sx, w_sy;
    logic signed [SAT_W-1:0]      w_dep;

    logic [LAT-1:0]               r_vld;
    logic [VIS_LAT-1:0]           r_vis;
    logic [SIZE_W-1:0]            r_width, r_height;
    logic [W-1:0]                 r_dep1, r_dep2;
    logic [W-1:0]                 r_sx, r_sy, r_sd;

    // Whole pipeline advances together; it holds only when the output waits.
    assign w_adv           = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_acc           = i_s_axis_tvalid & w_adv;

    // Load transfers write the matrix and drop out here.
    assign w_wr.we  = w_acc & (i_s_axis_tuser == MODE_LOAD);
    assign w_wr.idx = i_s_axis_tdata[MAT_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vis <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], w_acc & (i_s_axis_tuser == MODE_PROJECT)};
            r_vis <= {r_vis[VIS_LAT-2:0], w_vis_now};
        end
    end

    wsp_xform #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_wr     (w_wr),
        .i_wr_val (i_s_axis_tdata[MAT_IDX_W +: W]),
        .i_pos_x  ($signed(i_s_axis_tdata[MAT_IDX_W + W +: W])),
        .i_pos_y  ($signed(i_s_axis_tdata[MAT_IDX_W + 2 * W +: W])),
        .i_pos_z  ($signed(i_s_axis_tdata[MAT_IDX_W + 3 * W +: W])),
        .o_clip   (w_clip)
    );

    // Near-plane test on clip w; a failing point is zeroed at the output.
    assign w_vis_now = $signed(w_clip[3]) >= $signed(CLIP_BITS'(NEAR_W));

    // Divide |clip| * 2^F by clip w, then restore the sign (truncate toward zero).
    for (genvar g = 0; g < 3; g++) begin : g_div
        logic [CLIP_BITS-1:0] w_mag;
        assign w_neg[g] = w_clip[g][CLIP_BITS-1];
        assign w_mag    = w_neg[g] ? (~w_clip[g] + CLIP_BITS'(1)) : w_clip[g];
        assign w_num[g] = {w_mag, {FRAC_BITS{1'b0}}};

        wsp_div #(
            .NUM_W (DIV_NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_neg (w_neg[g]),
            .i_num (w_num[g]),
            .i_den (w_clip[3][DEN_W-1:0]),
            .o_quo (w_ndc[g])
        );
    end

    wsp_map #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_map (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_ndc_x  (w_ndc[0]),
        .i_ndc_y  (w_ndc[1]),
        .i_width  (r_width),
        .i_height (r_height),
        .o_sx     (w_sx),
        .o_sy     (w_sy)
    );

    // Depth travels alongside the two mapping stages.
    assign w_dep = sat_s(SAT_W'(w_ndc[2]), W);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dep1 <= w_dep[W-1:0];
            r_dep2 <= r_dep1;
            r_sx   <= r_vis[VIS_LAT-2] ? w_sx   : '0;
            r_sy   <= r_vis[VIS_LAT-2] ? w_sy   : '0;
            r_sd   <= r_vis[VIS_LAT-2] ? r_dep2 : '0;
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tuser  = r_vis[VIS_LAT-1];
    assign o_m_axis_tdata  = OUT_DW'({r_sd, r_sy, r_sx});

`ifndef ASSERT_OFF
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("hidden point carries nonzero coordinates");

    a_load_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_LOAD) |=> !r_vld[0])
        else $error("load transfer entered the projection pipeline");

    a_proj_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_PROJECT) |=> r_vld[0])
        else $error("project transfer lost at pipeline entry");
`endif

endmodule
